>>> hw/rtl/lvd_pkg.sv
// Package for the line value dilate filter.
// Holds register indexes, reset values, default sizes and the sequencer state type.
// No dependencies.
`default_nettype none

package lvd_pkg;

   localparam int MAX_KERNEL_DEF  = 16;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DILATE_VALUE      = 2'd0,
      CSR_KERNEL_SIZE       = 2'd1,
      CSR_KERNEL_MIDDLE     = 2'd2,
      CSR_HANDLE_BOUNDARIES = 2'd3
   } csr_index_type;

   localparam logic [15:0] DILATE_VALUE_RST      = 16'd0;
   localparam logic [4:0]  KERNEL_SIZE_RST       = 5'd3;
   localparam logic [3:0]  KERNEL_MIDDLE_RST     = 4'd1;
   localparam logic        HANDLE_BOUNDARIES_RST = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } seq_state_type;

endpackage

`default_nettype wire

>>> hw/rtl/line_value_dilate_filter_top.sv
// Top level of the line value dilate filter: register port, row of window cells,
// sequencer. Depends on lvd_pkg, lvd_cell and lvd_seq.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_sample, req_line_end
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_out_sample, rsp_out_line_end
//   csr     | in        | csr_write            | csr_index, csr_wdata
//
// An item that gives one result is accepted and shifted into the cell row, then
// the sequencer loads the result register in ST_RUN once the output is not stalled.
// A line end in boundary mode adds one result per flushed position, since the
// sequencer walks the cell row one position per cycle while the output is not stalled.
// Reset clears control state only; cell contents are never read before written.
// rsp_stall holds the result register and the walk; req_stall is high while walking.
`default_nettype none

module line_value_dilate_filter_top #(
   parameter int MAX_KERNEL  = lvd_pkg::MAX_KERNEL_DEF,
   parameter int SAMPLE_BITS = lvd_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [SAMPLE_BITS-1:0]        req_sample,
   input  wire logic                          req_line_end,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [SAMPLE_BITS-1:0]        rsp_out_sample,
   output logic                               rsp_out_line_end,
   input  wire logic                          csr_write,
   input  wire logic [lvd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lvd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import lvd_pkg::*;

   localparam int IDX_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int CNT_W = $clog2(MAX_KERNEL + 1);

   logic [15:0] dilate_value_ff, dilate_value_in;
   logic [4:0]  kernel_size_ff, kernel_size_in;
   logic [3:0]  kernel_middle_ff, kernel_middle_in;
   logic        handle_boundaries_ff, handle_boundaries_in;

   logic [SAMPLE_BITS-1:0] match_val;
   logic [SAMPLE_BITS-1:0] taps [MAX_KERNEL];
   logic [MAX_KERNEL-1:0]  hits;
   logic [SAMPLE_BITS-1:0] center;
   logic                   hit_any;
   logic                   shift_en;
   logic [IDX_W-1:0]       pos;
   logic [IDX_W-1:0]       lo;
   logic [IDX_W-1:0]       hi;

   always_comb begin
      dilate_value_in      = dilate_value_ff;
      kernel_size_in       = kernel_size_ff;
      kernel_middle_in     = kernel_middle_ff;
      handle_boundaries_in = handle_boundaries_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_DILATE_VALUE:      dilate_value_in      = csr_wdata[15:0];
            CSR_KERNEL_SIZE:       kernel_size_in       = csr_wdata[4:0];
            CSR_KERNEL_MIDDLE:     kernel_middle_in     = csr_wdata[3:0];
            CSR_HANDLE_BOUNDARIES: handle_boundaries_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dilate_value_ff      <= DILATE_VALUE_RST;
         kernel_size_ff       <= KERNEL_SIZE_RST;
         kernel_middle_ff     <= KERNEL_MIDDLE_RST;
         handle_boundaries_ff <= HANDLE_BOUNDARIES_RST;
      end else begin
         dilate_value_ff      <= dilate_value_in;
         kernel_size_ff       <= kernel_size_in;
         kernel_middle_ff     <= kernel_middle_in;
         handle_boundaries_ff <= handle_boundaries_in;
      end
   end

   assign match_val = SAMPLE_BITS'(dilate_value_ff);

   for (genvar i = 0; i < MAX_KERNEL; i++) begin : g_cell
      logic [SAMPLE_BITS-1:0] cell_din;
      if (i == 0) begin : g_head
         assign cell_din = req_sample;
      end else begin : g_body
         assign cell_din = taps[i-1];
      end
      lvd_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .IDX_W       (IDX_W),
         .POS         (i)
      ) u_cell (
         .clock     (clock),
         .shift_en  (shift_en),
         .din       (cell_din),
         .match_val (match_val),
         .lo        (lo),
         .hi        (hi),
         .dout      (taps[i]),
         .hit       (hits[i])
      );
   end

   assign hit_any = |hits;
   assign center  = taps[pos];

   lvd_seq #(
      .MAX_KERNEL  (MAX_KERNEL),
      .SAMPLE_BITS (SAMPLE_BITS),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_line_end      (req_line_end),
      .req_stall         (req_stall),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_sample    (rsp_out_sample),
      .rsp_out_line_end  (rsp_out_line_end),
      .kernel_size       (kernel_size_ff),
      .kernel_middle     (kernel_middle_ff),
      .handle_boundaries (handle_boundaries_ff),
      .match_val         (match_val),
      .center            (center),
      .hit_any           (hit_any),
      .shift_en          (shift_en),
      .pos               (pos),
      .lo                (lo),
      .hi                (hi)
   );

endmodule

`default_nettype wire

>>> hw/rtl/lvd_cell.sv
// One window cell: holds one sample, shifts it on to the next cell, flags a match
// against the dilate value when its position lies inside the current window range.
// Depends on nothing but its parameters.
`default_nettype none

module lvd_cell #(
   parameter int SAMPLE_BITS = 16,
   parameter int IDX_W       = 4,
   parameter int POS         = 0
) (
   input  wire logic                   clock,
   input  wire logic                   shift_en,
   input  wire logic [SAMPLE_BITS-1:0] din,
   input  wire logic [SAMPLE_BITS-1:0] match_val,
   input  wire logic [IDX_W-1:0]       lo,
   input  wire logic [IDX_W-1:0]       hi,
   output logic      [SAMPLE_BITS-1:0] dout,
   output logic                        hit
);

   logic [SAMPLE_BITS-1:0] data_ff;
   logic [SAMPLE_BITS-1:0] data_in;

   localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

   always_comb begin
      data_in = shift_en ? din : data_ff;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign dout = data_ff;
   assign hit  = (data_ff == match_val) && (MY_POS >= lo) && (MY_POS <= hi);

endmodule

`default_nettype wire

>>> hw/rtl/lvd_seq.sv
// Sequencer: input handshake, line position count, window geometry, the walk over
// the positions owed by each item and the result register.
// Depends on lvd_pkg.
`default_nettype none

module lvd_seq #(
   parameter int MAX_KERNEL  = 16,
   parameter int SAMPLE_BITS = 16,
   parameter int IDX_W       = 4,
   parameter int CNT_W       = 5
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_line_end,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [SAMPLE_BITS-1:0] rsp_out_sample,
   output logic                        rsp_out_line_end,
   input  wire logic [4:0]             kernel_size,
   input  wire logic [3:0]             kernel_middle,
   input  wire logic                   handle_boundaries,
   input  wire logic [SAMPLE_BITS-1:0] match_val,
   input  wire logic [SAMPLE_BITS-1:0] center,
   input  wire logic                   hit_any,
   output logic                        shift_en,
   output logic      [IDX_W-1:0]       pos,
   output logic      [IDX_W-1:0]       lo,
   output logic      [IDX_W-1:0]       hi
);

   import lvd_pkg::*;

   localparam int KW = (CNT_W > 5) ? CNT_W : 5;
   localparam int MW = (CNT_W > 4) ? CNT_W : 4;
   localparam int HW = IDX_W + 1;

   seq_state_type state_ff, state_in;
   logic [CNT_W-1:0]       seen_ff, seen_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   logic                   flush_ff, flush_in;
   logic                   last_ff, last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                   rsp_line_end_ff, rsp_line_end_in;

   logic [KW-1:0]    ks_w;
   logic [CNT_W-1:0] size;
   logic [CNT_W-1:0] size_m1;
   logic [MW-1:0]    km_w;
   logic [MW-1:0]    sm1_w;
   logic [IDX_W-1:0] prior;
   logic [IDX_W-1:0] after;
   logic [CNT_W-1:0] count_new;
   logic [HW-1:0]    hi_sum;
   logic [HW-1:0]    count_m1;
   logic             accept;
   logic             load;
   logic             final_pos;

   // window geometry from the registers
   always_comb begin
      ks_w = KW'(kernel_size);
      if (ks_w == '0) begin
         size = CNT_W'(1);
      end else if (ks_w > KW'(MAX_KERNEL)) begin
         size = CNT_W'(MAX_KERNEL);
      end else begin
         size = CNT_W'(ks_w);
      end
      size_m1 = size - CNT_W'(1);
      km_w    = MW'(kernel_middle);
      sm1_w   = MW'(size_m1);
      prior   = IDX_W'((km_w > sm1_w) ? sm1_w : km_w);
      after   = IDX_W'(size_m1) - prior;
   end

   // range of cells searched for the position being emitted
   always_comb begin
      lo       = (pos_ff >= after) ? (pos_ff - after) : '0;
      hi_sum   = HW'(pos_ff) + HW'(prior);
      count_m1 = HW'(count_ff - CNT_W'(1));
      hi       = IDX_W'((hi_sum > count_m1) ? count_m1 : hi_sum);
   end

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign load      = (state_ff == ST_RUN) && (!rsp_valid_ff || !rsp_stall);
   assign final_pos = !flush_ff || (pos_ff == '0);
   assign count_new = (seen_ff == CNT_W'(MAX_KERNEL)) ? seen_ff : seen_ff + CNT_W'(1);

   always_comb begin
      state_in        = state_ff;
      seen_in         = seen_ff;
      count_in        = count_ff;
      pos_in          = pos_ff;
      flush_in        = flush_ff;
      last_in         = last_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_sample_in   = rsp_sample_ff;
      rsp_line_end_in = rsp_line_end_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               seen_in  = req_line_end ? '0 : count_new;
               count_in = count_new;
               last_in  = req_line_end;
               pos_in   = after;
               flush_in = 1'b0;
               if (handle_boundaries) begin
                  if (req_line_end) begin
                     flush_in = 1'b1;
                     state_in = ST_RUN;
                     if (CNT_W'(after) >= count_new) begin
                        pos_in = IDX_W'(count_new - CNT_W'(1));
                     end
                  end else if (CNT_W'(after) < count_new) begin
                     state_in = ST_RUN;
                  end
               end else if (count_new >= size) begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (load) begin
               rsp_valid_in    = 1'b1;
               rsp_sample_in   = hit_any ? match_val : center;
               rsp_line_end_in = last_ff && final_pos;
               if (final_pos) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in = pos_ff - IDX_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff        <= count_in;
      pos_ff          <= pos_in;
      flush_ff        <= flush_in;
      last_ff         <= last_in;
      rsp_sample_ff   <= rsp_sample_in;
      rsp_line_end_ff <= rsp_line_end_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign shift_en         = accept;
   assign pos              = pos_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_sample   = rsp_sample_ff;
   assign rsp_out_line_end = rsp_line_end_ff;

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CNT_W'(MAX_KERNEL))
      else $error("line position count above kernel depth");

   a_pos_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (CNT_W'(pos_ff) < count_ff))
      else $error("emitting a position outside the written window");

   a_line_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req_line_end) |=> (seen_ff == '0))
      else $error("line position count not cleared at line end");

   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      (load && rsp_line_end_in) |=> (state_ff == ST_IDLE))
      else $error("sequencer still running after line end result");

endmodule

`default_nettype wire

>>> dv/tb_line_value_dilate_filter_top.sv
// Testbench for line_value_dilate_filter_top: directed and random sample lines under
// changing register settings. Each result is checked against a dilation model kept here.
// Depends on lvd_pkg and the filter RTL.
module tb_line_value_dilate_filter_top;
   import lvd_pkg::*;

   localparam int KMAX   = MAX_KERNEL_DEF;
   localparam int SBITS  = SAMPLE_BITS_DEF;
   localparam int SETTLE = 40;

   typedef struct packed {
      logic [SBITS-1:0] pixel;
      logic             line_end;
   } dilated_pixel_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [SBITS-1:0]       req_sample = '0;
   logic                   req_line_end = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [SBITS-1:0]       rsp_out_sample;
   logic                   rsp_out_line_end;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_DILATE_VALUE;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int send_idle_pct = 37;
   int recv_idle_pct = 55;
   int error_count = 0;
   int items_sent = 0;

   dilated_pixel_type dilated_q[$];

   logic [15:0]      dilate_value_q;
   logic [4:0]       kernel_size_q;
   logic [3:0]       kernel_middle_q;
   logic             boundaries_q;
   logic [SBITS-1:0] line_window [KMAX];
   int               line_fill;

   line_value_dilate_filter_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_line_end     (req_line_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_sample   (rsp_out_sample),
      .rsp_out_line_end (rsp_out_line_end),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   task automatic report_error(input string msg);
      error_count++;
      $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   always @(posedge clock) begin : check_result
      dilated_pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (dilated_q.size() == 0) begin
            report_error($sformatf("unexpected item %h line_end %b",
                                   rsp_out_sample, rsp_out_line_end));
         end else begin
            want = dilated_q.pop_front();
            if (rsp_out_sample !== want.pixel)
               report_error($sformatf("out_sample %h, expected %h",
                                      rsp_out_sample, want.pixel));
            if (rsp_out_line_end !== want.line_end)
               report_error($sformatf("out_line_end %b, expected %b (sample %h)",
                                      rsp_out_line_end, want.line_end, want.pixel));
         end
      end
   end

   // Window indexes run newest first; d is the centre position.
   function automatic logic [SBITS-1:0] dilate_pixel(input int d, input int count,
                                                     input int prior, input int after);
      int lo;
      int hi;
      lo = (d >= after) ? d - after : 0;
      hi = d + prior;
      if (hi > count - 1) hi = count - 1;
      for (int k = lo; k <= hi && k < KMAX; k++)
         if (line_window[k] == dilate_value_q[SBITS-1:0]) return dilate_value_q[SBITS-1:0];
      return line_window[d % KMAX];
   endfunction

   function automatic void predict_dilation(input logic [SBITS-1:0] smp, input logic last);
      dilated_pixel_type step_out [KMAX];
      int size;
      int prior;
      int after;
      int n;
      size = kernel_size_q;
      if (size < 1) size = 1;
      if (size > KMAX) size = KMAX;
      prior = kernel_middle_q;
      if (prior > size - 1) prior = size - 1;
      after = size - 1 - prior;
      for (int k = KMAX - 1; k > 0; k--) line_window[k] = line_window[k-1];
      line_window[0] = smp;
      if (line_fill < KMAX) line_fill++;
      n = 0;
      if (boundaries_q) begin
         if (after < line_fill) begin
            step_out[n] = '{dilate_pixel(after, line_fill, prior, after), 1'b0};
            n++;
         end
         if (last) begin
            for (int d = after; d > 0; d--) begin
               if (d - 1 < line_fill) begin
                  step_out[n] = '{dilate_pixel(d - 1, line_fill, prior, after), 1'b0};
                  n++;
               end
            end
         end
      end else if (line_fill >= size) begin
         step_out[n] = '{dilate_pixel(after, line_fill, prior, after), 1'b0};
         n++;
      end
      if (last) begin
         if (n > 0) step_out[n-1].line_end = 1'b1;
         line_fill = 0;
      end
      for (int i = 0; i < n; i++) dilated_q.push_back(step_out[i]);
   endfunction

   function automatic logic [15:0] with_junk(input int value, input int bits);
      logic [15:0] mask;
      mask = (16'd1 << bits) - 16'd1;
      return (16'($urandom) & ~mask) | (16'(value) & mask);
   endfunction

   task automatic configure(input logic [15:0] dv, input int ks, input int km, input int hb);
      logic [15:0] ks_w;
      logic [15:0] km_w;
      logic [15:0] hb_w;
      ks_w = with_junk(ks, 5);
      km_w = with_junk(km, 4);
      hb_w = with_junk(hb, 1);
      csr_write <= 1'b1;
      csr_index <= CSR_DILATE_VALUE;
      csr_wdata <= dv;
      @(posedge clock);
      csr_index <= CSR_KERNEL_SIZE;
      csr_wdata <= ks_w;
      @(posedge clock);
      csr_index <= CSR_KERNEL_MIDDLE;
      csr_wdata <= km_w;
      @(posedge clock);
      csr_index <= CSR_HANDLE_BOUNDARIES;
      csr_wdata <= hb_w;
      @(posedge clock);
      csr_write <= 1'b0;
      dilate_value_q  = dv;
      kernel_size_q   = ks_w[4:0];
      kernel_middle_q = km_w[3:0];
      boundaries_q    = hb_w[0];
   endtask

   task automatic send_item(input logic [SBITS-1:0] smp, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_sample   <= smp;
      req_line_end <= last;
      do @(posedge clock); while (req_stall);
      predict_dilation(smp, last);
      items_sent++;
   endtask

   task automatic wait_drained(input int settle);
      req_valid <= 1'b0;
      while (dilated_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   function automatic logic [SBITS-1:0] pick_sample();
      return ($urandom_range(99) < 25) ? dilate_value_q[SBITS-1:0] : SBITS'($urandom);
   endfunction

   task automatic send_line(input int len, input bit complete);
      for (int i = 0; i < len; i++) send_item(pick_sample(), complete && (i == len - 1));
   endtask

   task automatic test_default_config();
      send_item(16'hFFFF, 1'b0);
      send_item(16'h0000, 1'b0);
      send_item(16'hAAAA, 1'b0);
      send_item(16'h5555, 1'b0);
      send_item(16'h1234, 1'b1);
   endtask

   task automatic test_kernel_out_of_range();
      wait_drained(SETTLE);
      configure(16'hFFFF, 0, 15, 1);
      send_item(16'hFFFF, 1'b0);
      send_item(16'h0001, 1'b1);
      wait_drained(SETTLE);
      configure(16'h8001, 31, 0, 1);
      send_item(16'h8001, 1'b0);
      send_item(16'h1234, 1'b0);
      send_item(16'h4321, 1'b1);
   endtask

   task automatic test_short_line_no_boundaries();
      wait_drained(SETTLE);
      configure(16'h00FF, 5, 2, 0);
      send_item(16'h00FF, 1'b0);
      send_item(16'h7F00, 1'b0);
      send_item(16'hC3C3, 1'b1);
   endtask

   task automatic test_mid_line_change();
      send_item(16'h0F0F, 1'b0);
      send_item(16'h5A5A, 1'b0);
      send_item(16'hF0F0, 1'b0);
      send_item(16'h00FF, 1'b0);
      send_item(16'h3C3C, 1'b0);
      send_item(16'h9999, 1'b0);
      wait_drained(SETTLE);
      configure(16'h5A5A, 2, 1, 1);
      send_item(16'h2468, 1'b0);
      send_item(16'h5A5A, 1'b1);
   endtask

   task automatic test_full_flush();
      wait_drained(SETTLE);
      configure(16'($urandom), KMAX, 0, 1);
      send_line(KMAX + 2, 1'b1);
   endtask

   task automatic random_config();
      int ks;
      int ks_eff;
      int km;
      logic [15:0] dv;
      case ($urandom_range(9))
         0: ks = 0;
         1: ks = KMAX;
         2: ks = $urandom_range(KMAX + 1, 31);
         3: ks = 1;
         default: ks = $urandom_range(2, 7);
      endcase
      ks_eff = (ks < 1) ? 1 : (ks > KMAX) ? KMAX : ks;
      km = ($urandom_range(99) < 30) ? $urandom_range(15) : $urandom_range(ks_eff - 1);
      case ($urandom_range(9))
         0, 1: dv = 16'h0000;
         2: dv = 16'hFFFF;
         default: dv = 16'($urandom);
      endcase
      configure(dv, ks, km, $urandom_range(1));
   endtask

   task automatic test_random_lines(input int target);
      int stop_at;
      int phase_end;
      int len;
      int pick;
      stop_at = items_sent + target;
      while (items_sent < stop_at) begin
         wait_drained(SETTLE);
         random_config();
         phase_end = items_sent + $urandom_range(20, 50);
         while (items_sent < phase_end && items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (kernel_size_q >= KMAX && $urandom_range(99) < 40)
               len = $urandom_range(KMAX, KMAX + 4);
            else if (pick < 75)
               len = $urandom_range(1, 8);
            else if (pick < 95)
               len = $urandom_range(9, 20);
            else
               len = 1;
            if ($urandom_range(99) < 8) wait_drained(0);
            send_line(len, $urandom_range(99) < 85);
         end
      end
   endtask

   initial begin
      dilate_value_q  = DILATE_VALUE_RST;
      kernel_size_q   = KERNEL_SIZE_RST;
      kernel_middle_q = KERNEL_MIDDLE_RST;
      boundaries_q    = HANDLE_BOUNDARIES_RST;
      for (int k = 0; k < KMAX; k++) line_window[k] = '0;
      line_fill = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_config();
      test_kernel_out_of_range();
      test_short_line_no_boundaries();
      test_mid_line_change();
      test_full_flush();
      test_random_lines(100);
      send_idle_pct = 55;
      recv_idle_pct = 37;
      test_random_lines(120);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_lines(120);
      wait_drained(SETTLE);
      if (error_count == 0 && dilated_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #400000;
      $display("timeout, %0d items still expected", dilated_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/lvd_pkg.sv
hw/rtl/lvd_cell.sv
hw/rtl/lvd_seq.sv
hw/rtl/line_value_dilate_filter_top.sv
dv/tb_line_value_dilate_filter_top.sv
